// ----- design/ctbt_pkg.sv -----
// Shared types and constants for the color threshold bounding box tracker.
package ctbt_pkg;

  localparam int CHAN_W    = 8;
  localparam int SIZE_W    = 13;
  localparam int COORD_W   = 12;
  localparam int CENTER_W  = 13;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 13;

  // Configuration register map
  localparam logic [CFG_IDX_W-1:0] REG_RED_LOW      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_HIGH     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_LOW    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_HIGH   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_LOW     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_HIGH    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd7;

  // Register reset values
  localparam logic [CHAN_W-1:0] RED_LOW_RST      = 8'd230;
  localparam logic [CHAN_W-1:0] RED_HIGH_RST     = 8'd255;
  localparam logic [CHAN_W-1:0] GREEN_LOW_RST    = 8'd0;
  localparam logic [CHAN_W-1:0] GREEN_HIGH_RST   = 8'd15;
  localparam logic [CHAN_W-1:0] BLUE_LOW_RST     = 8'd0;
  localparam logic [CHAN_W-1:0] BLUE_HIGH_RST    = 8'd15;
  localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 13'd1280;
  localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 13'd720;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic                found;
    logic [CENTER_W-1:0] center_row;
    logic [CENTER_W-1:0] center_col;
    logic [COORD_W-1:0]  row_min;
    logic [COORD_W-1:0]  row_max;
    logic [COORD_W-1:0]  col_min;
    logic [COORD_W-1:0]  col_max;
  } result_t;

endpackage

// ----- design/color_threshold_bbox_tracker_top.sv -----
// Top level of the color threshold bounding box tracker.
//
// Pixels enter in raster order, one beat per clock, and the block keeps its own
// row and column position. A pixel matches when red, green and blue each lie in
// their inclusive configured bounds; matching pixels widen a bounding box. The
// beat that carries the last pixel of a frame produces one result beat, shown
// the cycle after it is taken, with the found flag, the box edges (0-based) and
// the 1-based center of each axis; all fields read 0 when nothing matched. The
// tracking state then clears for the next frame. Throughput is one pixel per
// clock, limited only by the single result register: in_stall rises only for
// the last pixel of a frame while the previous frame's result is still stalled.
// Frame sizes of 0 act as 1, sizes above MAX_WIDTH/MAX_HEIGHT act as those
// limits. Registers may be written between frames via the cfg port, which is
// always ready.
module color_threshold_bbox_tracker_top #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  ctbt_pkg::pixel_t                     in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output ctbt_pkg::result_t                    out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ctbt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ctbt_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int EWW = (ctbt_pkg::SIZE_W > CW + 1) ? ctbt_pkg::SIZE_W : CW + 1;
  localparam int EHW = (ctbt_pkg::SIZE_W > RW + 1) ? ctbt_pkg::SIZE_W : RW + 1;

  // configuration registers
  logic [ctbt_pkg::CHAN_W-1:0] red_low_r, red_high_r;
  logic [ctbt_pkg::CHAN_W-1:0] green_low_r, green_high_r;
  logic [ctbt_pkg::CHAN_W-1:0] blue_low_r, blue_high_r;
  logic [ctbt_pkg::SIZE_W-1:0] frame_width_r, frame_height_r;

  // frame tracking state
  logic [CW-1:0] col_count_r, col_count_nxt;
  logic [RW-1:0] row_count_r, row_count_nxt;
  logic [RW-1:0] min_row_r, max_row_r, min_row_nxt, max_row_nxt;
  logic [CW-1:0] min_col_r, max_col_r, min_col_nxt, max_col_nxt;
  logic          any_match_r, any_match_nxt;

  logic                out_valid_r;
  ctbt_pkg::result_t   out_data_r, result_nxt;

  logic [EWW-1:0] eff_w;
  logic [EHW-1:0] eff_h;
  logic           last_col, last_row, frame_end;
  logic           pix_match, in_take;
  logic [RW:0]    center_row;
  logic [CW:0]    center_col;

  assign cfg_ready = 1'b1;

  // clamp frame size to [1, MAX]
  always_comb begin
    if (frame_width_r == '0) begin
      eff_w = EWW'(1);
    end else if (EWW'(frame_width_r) > EWW'(MAX_WIDTH)) begin
      eff_w = EWW'(MAX_WIDTH);
    end else begin
      eff_w = EWW'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      eff_h = EHW'(1);
    end else if (EHW'(frame_height_r) > EHW'(MAX_HEIGHT)) begin
      eff_h = EHW'(MAX_HEIGHT);
    end else begin
      eff_h = EHW'(frame_height_r);
    end
  end

  assign last_col  = EWW'(col_count_r) >= (eff_w - EWW'(1));
  assign last_row  = EHW'(row_count_r) >= (eff_h - EHW'(1));
  assign frame_end = last_col && last_row;

  // hold the input only when this beat closes a frame and the result slot is busy
  assign in_stall = out_valid_r && out_stall && frame_end;
  assign in_take  = in_valid && !in_stall;

  assign pix_match = (in_data.red   >= red_low_r)   && (in_data.red   <= red_high_r)   &&
                     (in_data.green >= green_low_r) && (in_data.green <= green_high_r) &&
                     (in_data.blue  >= blue_low_r)  && (in_data.blue  <= blue_high_r);

  always_comb begin
    min_row_nxt   = min_row_r;
    max_row_nxt   = max_row_r;
    min_col_nxt   = min_col_r;
    max_col_nxt   = max_col_r;
    any_match_nxt = any_match_r;
    if (pix_match) begin
      any_match_nxt = 1'b1;
      if (!any_match_r) begin
        min_row_nxt = row_count_r;
        max_row_nxt = row_count_r;
        min_col_nxt = col_count_r;
        max_col_nxt = col_count_r;
      end else begin
        if (row_count_r < min_row_r) min_row_nxt = row_count_r;
        if (row_count_r > max_row_r) max_row_nxt = row_count_r;
        if (col_count_r < min_col_r) min_col_nxt = col_count_r;
        if (col_count_r > max_col_r) max_col_nxt = col_count_r;
      end
    end

    if (!last_col) begin
      col_count_nxt = col_count_r + CW'(1);
      row_count_nxt = row_count_r;
    end else if (!last_row) begin
      col_count_nxt = '0;
      row_count_nxt = row_count_r + RW'(1);
    end else begin
      col_count_nxt = '0;
      row_count_nxt = '0;
    end
  end

  assign center_row = (RW+1)'(min_row_nxt) + (RW+1)'((max_row_nxt - min_row_nxt) >> 1)
                      + (RW+1)'(1);
  assign center_col = (CW+1)'(min_col_nxt) + (CW+1)'((max_col_nxt - min_col_nxt) >> 1)
                      + (CW+1)'(1);

  always_comb begin
    result_nxt = '0;
    if (any_match_nxt) begin
      result_nxt.found      = 1'b1;
      result_nxt.center_row = ctbt_pkg::CENTER_W'(center_row);
      result_nxt.center_col = ctbt_pkg::CENTER_W'(center_col);
      result_nxt.row_min    = ctbt_pkg::COORD_W'(min_row_nxt);
      result_nxt.row_max    = ctbt_pkg::COORD_W'(max_row_nxt);
      result_nxt.col_min    = ctbt_pkg::COORD_W'(min_col_nxt);
      result_nxt.col_max    = ctbt_pkg::COORD_W'(max_col_nxt);
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_low_r      <= ctbt_pkg::RED_LOW_RST;
      red_high_r     <= ctbt_pkg::RED_HIGH_RST;
      green_low_r    <= ctbt_pkg::GREEN_LOW_RST;
      green_high_r   <= ctbt_pkg::GREEN_HIGH_RST;
      blue_low_r     <= ctbt_pkg::BLUE_LOW_RST;
      blue_high_r    <= ctbt_pkg::BLUE_HIGH_RST;
      frame_width_r  <= ctbt_pkg::FRAME_WIDTH_RST;
      frame_height_r <= ctbt_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ctbt_pkg::REG_RED_LOW:      red_low_r      <= cfg_data[ctbt_pkg::CHAN_W-1:0];
        ctbt_pkg::REG_RED_HIGH:     red_high_r     <= cfg_data[ctbt_pkg::CHAN_W-1:0];
        ctbt_pkg::REG_GREEN_LOW:    green_low_r    <= cfg_data[ctbt_pkg::CHAN_W-1:0];
        ctbt_pkg::REG_GREEN_HIGH:   green_high_r   <= cfg_data[ctbt_pkg::CHAN_W-1:0];
        ctbt_pkg::REG_BLUE_LOW:     blue_low_r     <= cfg_data[ctbt_pkg::CHAN_W-1:0];
        ctbt_pkg::REG_BLUE_HIGH:    blue_high_r    <= cfg_data[ctbt_pkg::CHAN_W-1:0];
        ctbt_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[ctbt_pkg::SIZE_W-1:0];
        ctbt_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data[ctbt_pkg::SIZE_W-1:0];
        default: ;  // drop writes outside the map
      endcase
    end
  end

  // frame state: advance on every accepted pixel, clear at frame end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
      min_row_r   <= '0;
      max_row_r   <= '0;
      min_col_r   <= '0;
      max_col_r   <= '0;
      any_match_r <= 1'b0;
    end else if (in_take) begin
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
      if (frame_end) begin
        min_row_r   <= '0;
        max_row_r   <= '0;
        min_col_r   <= '0;
        max_col_r   <= '0;
        any_match_r <= 1'b0;
      end else begin
        min_row_r   <= min_row_nxt;
        max_row_r   <= max_row_nxt;
        min_col_r   <= min_col_nxt;
        max_col_r   <= max_col_nxt;
        any_match_r <= any_match_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take && frame_end) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && frame_end) begin
      out_data_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
